FILE: rtl/jse_pkg.sv
package jse_pkg;

    // Character codes used by the classifier and the byte sequencer.
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_LF        = 8'h0a;
    localparam logic [7:0] CHAR_CR        = 8'h0d;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_N         = 8'h6e;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CTRL_LIMIT     = 8'h20;

    // Budget constants.
    localparam logic [15:0] BUFFER_SIZE_RESET = 16'd256;
    localparam logic [15:0] MIN_BUFFER        = 16'd3;
    localparam logic [16:0] ENCODE_HEADROOM   = 17'd8;

    // Input request and result byte.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_string;
    } out_item_t;

    // What the back end has to emit for one accepted request.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PLAIN,
        CMD_ESC,
        CMD_UHEX,
        CMD_CLOSE,
        CMD_CLOSE_LAST,
        CMD_ZERO
    } cmd_kind_t;

    typedef struct packed {
        logic       prefix_quote;
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

endpackage

FILE: rtl/json_string_escaper_core.sv
// JSON string escaper. Push the characters of a string, then one request with
// end_of_string set; the result queue yields the string as a quoted JSON literal
// followed by a zero terminator if it fits, last_of_string marking the final byte.
// The front end classifies each request in the cycle it is accepted and keeps
// the output budget (buffer_size, written through the cfg port, reset 256);
// commands wait in a CMD_DEPTH-entry queue for the back end, which emits one
// byte per cycle from its output register while pop keeps it drained. The first
// result of a request passes through the command queue and then the output
// register before it shows on the result ports. A plain character yields one
// output byte, a two-byte escape or a closing quote with terminator two, a
// control character six, and the first request of a string one more for the
// opening quote; the back end's one byte per cycle, while pop keeps up, sets the
// sustained rate, and push sees full only while the command queue is full.
module json_string_escaper_core #(
    parameter int CMD_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  jse_pkg::in_item_t   in_item,
    output logic                empty,
    input  logic                pop,
    output jse_pkg::out_item_t  out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    logic          take;
    logic          cmd_write;
    jse_pkg::cmd_t cmd;
    jse_pkg::cmd_t head_cmd;
    logic          head_valid;
    logic          head_done;

    assign take      = push && !full;
    assign cfg_ready = 1'b1;

    jse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_item   (in_item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_write (cmd_write),
        .cmd       (cmd)
    );

    jse_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .write     (cmd_write),
        .write_cmd (cmd),
        .read      (head_done),
        .head_cmd  (head_cmd),
        .not_empty (head_valid),
        .is_full   (full)
    );

    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .head_done  (head_done),
        .pop        (pop),
        .empty      (empty),
        .out_item   (out_item)
    );

endmodule

FILE: rtl/jse_front.sv
module jse_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  jse_pkg::in_item_t    in_item,
    input  logic                 cfg_write,
    input  logic [15:0]          cfg_data,
    output logic                 cmd_write,
    output jse_pkg::cmd_t        cmd
);

    logic        open_reg, open_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] bsize_reg, bsize_next;

    logic        starting;
    logic        too_small;
    logic [15:0] count_base;
    logic [15:0] count_after_prefix;
    logic [15:0] count_after_close;
    logic        fits;
    logic        emit;
    logic [2:0]  body_len;
    jse_pkg::cmd_kind_t char_kind;
    logic [7:0]  char_data;

    // Escape classification of one character.
    always_comb
    begin
        char_kind = jse_pkg::CMD_ESC;
        char_data = in_item.char_byte;
        body_len  = 3'd2;
        unique case (in_item.char_byte)
            jse_pkg::CHAR_QUOTE:     char_data = jse_pkg::CHAR_QUOTE;
            jse_pkg::CHAR_BACKSLASH: char_data = jse_pkg::CHAR_BACKSLASH;
            jse_pkg::CHAR_LF:        char_data = jse_pkg::CHAR_N;
            jse_pkg::CHAR_CR:        char_data = jse_pkg::CHAR_R;
            jse_pkg::CHAR_TAB:       char_data = jse_pkg::CHAR_T;
            default:
            begin
                if (in_item.char_byte < jse_pkg::CTRL_LIMIT)
                begin
                    char_kind = jse_pkg::CMD_UHEX;
                    body_len  = 3'd6;
                end
                else
                begin
                    char_kind = jse_pkg::CMD_PLAIN;
                    body_len  = 3'd1;
                end
            end
        endcase
    end

    // String state, output budget and the command for the back end.
    always_comb
    begin
        starting           = !open_reg;
        too_small          = bsize_reg < jse_pkg::MIN_BUFFER;
        count_base         = starting ? 16'd0 : count_reg;
        count_after_prefix = count_base + {15'd0, starting};
        count_after_close  = count_after_prefix + 16'd1;
        fits               = ({1'b0, count_after_prefix} + jse_pkg::ENCODE_HEADROOM)
                             < {1'b0, bsize_reg};

        cmd.prefix_quote = starting && !too_small;
        cmd.kind         = jse_pkg::CMD_NONE;
        cmd.data         = char_data;
        emit             = 1'b0;
        open_next        = open_reg;
        count_next       = count_reg;

        if (starting && too_small)
        begin
            cmd.kind = jse_pkg::CMD_ZERO;
            emit     = in_item.end_of_string;
            if (take)
            begin
                count_next = 16'd0;
            end
        end
        else if (in_item.end_of_string)
        begin
            cmd.kind = (count_after_close < bsize_reg) ? jse_pkg::CMD_CLOSE
                                                       : jse_pkg::CMD_CLOSE_LAST;
            emit     = 1'b1;
            if (take)
            begin
                open_next  = 1'b0;
                count_next = 16'd0;
            end
        end
        else
        begin
            emit = starting || fits;
            if (fits)
            begin
                cmd.kind = char_kind;
            end
            if (take)
            begin
                open_next  = 1'b1;
                count_next = fits ? count_after_prefix + {13'd0, body_len}
                                  : count_after_prefix;
            end
        end

        bsize_next = cfg_write ? cfg_data : bsize_reg;
        cmd_write  = take && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            count_reg <= 16'd0;
            bsize_reg <= jse_pkg::BUFFER_SIZE_RESET;
        end
        else
        begin
            open_reg  <= open_next;
            count_reg <= count_next;
            bsize_reg <= bsize_next;
        end
    end

endmodule

FILE: rtl/jse_cmd_fifo.sv
module jse_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          write,
    input  jse_pkg::cmd_t write_cmd,
    input  logic          read,
    output jse_pkg::cmd_t head_cmd,
    output logic          not_empty,
    output logic          is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    jse_pkg::cmd_t entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    // Pointer and fill-level bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (write)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (read)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (write && !read)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (read && !write)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign not_empty = fill_reg != '0;
    assign is_full   = fill_reg == FULL_CNT;

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            entry_reg[wr_ptr_reg] <= write_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: rtl/jse_back.sv
module jse_back (
    input  logic                clk,
    input  logic                rst_n,
    input  jse_pkg::cmd_t       head_cmd,
    input  logic                head_valid,
    output logic                head_done,
    input  logic                pop,
    output logic                empty,
    output jse_pkg::out_item_t  out_item
);

    logic [2:0]         step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    jse_pkg::out_item_t out_item_reg, out_item_next;

    logic [2:0]  body_len;
    logic [2:0]  total_len;
    logic [2:0]  body_step;
    logic        is_final;
    logic        load;
    logic [7:0]  cur_byte;
    logic        cur_last;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    endfunction

    // Length of the command's body and the byte at the current step.
    always_comb
    begin
        body_step = step_reg - {2'd0, head_cmd.prefix_quote};
        cur_byte  = jse_pkg::CHAR_NUL;
        cur_last  = 1'b0;
        unique case (head_cmd.kind)
            jse_pkg::CMD_NONE:
            begin
                body_len = 3'd0;
            end
            jse_pkg::CMD_PLAIN:
            begin
                body_len = 3'd1;
                cur_byte = head_cmd.data;
            end
            jse_pkg::CMD_ESC:
            begin
                body_len = 3'd2;
                cur_byte = (body_step == 3'd0) ? jse_pkg::CHAR_BACKSLASH : head_cmd.data;
            end
            jse_pkg::CMD_UHEX:
            begin
                body_len = 3'd6;
                unique case (body_step)
                    3'd0:    cur_byte = jse_pkg::CHAR_BACKSLASH;
                    3'd1:    cur_byte = jse_pkg::CHAR_U;
                    3'd2:    cur_byte = jse_pkg::CHAR_ZERO;
                    3'd3:    cur_byte = jse_pkg::CHAR_ZERO;
                    3'd4:    cur_byte = hex_char(head_cmd.data[7:4]);
                    default: cur_byte = hex_char(head_cmd.data[3:0]);
                endcase
            end
            jse_pkg::CMD_CLOSE:
            begin
                body_len = 3'd2;
                cur_byte = (body_step == 3'd0) ? jse_pkg::CHAR_QUOTE : jse_pkg::CHAR_NUL;
                cur_last = body_step != 3'd0;
            end
            jse_pkg::CMD_CLOSE_LAST:
            begin
                body_len = 3'd1;
                cur_byte = jse_pkg::CHAR_QUOTE;
                cur_last = 1'b1;
            end
            jse_pkg::CMD_ZERO:
            begin
                body_len = 3'd1;
                cur_last = 1'b1;
            end
            default:
            begin
                body_len = 3'd0;
            end
        endcase

        // The opening quote goes ahead of the body.
        if (head_cmd.prefix_quote && step_reg == 3'd0)
        begin
            cur_byte = jse_pkg::CHAR_QUOTE;
            cur_last = 1'b0;
        end

        total_len = body_len + {2'd0, head_cmd.prefix_quote};
        is_final  = step_reg == (total_len - 3'd1);
    end

    // Output register: refill whenever it is empty or being popped.
    always_comb
    begin
        load           = head_valid && (!out_valid_reg || pop);
        head_done      = load && is_final;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (load)
        begin
            step_next                    = is_final ? 3'd0 : step_reg + 3'd1;
            out_valid_next               = 1'b1;
            out_item_next.out_byte       = cur_byte;
            out_item_next.last_of_string = cur_last;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_item_reg;

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/jse_checker.sv
module jse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input jse_pkg::out_item_t out_item
);

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed while waiting");

    // The zero byte only ever appears as a terminator.
    a_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.out_byte == jse_pkg::CHAR_NUL) |-> out_item.last_of_string)
        else $error("zero byte not marked last");

    // The last byte of a string is a closing quote or the terminator.
    a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.last_of_string) |->
            (out_item.out_byte == jse_pkg::CHAR_NUL ||
             out_item.out_byte == jse_pkg::CHAR_QUOTE))
        else $error("string ended on unexpected byte");

    // Control characters never pass through unescaped.
    a_no_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.out_byte < jse_pkg::CTRL_LIMIT) |->
            (out_item.out_byte == jse_pkg::CHAR_NUL))
        else $error("raw control byte in output");

endmodule

bind json_string_escaper_core jse_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

FILE: tb/sv/testbench.sv
module testbench;

    localparam logic [7:0] CHAR_A_LOWER  = 8'h61;
    localparam int         SETTLE_CYCLES = 32;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         STUCK_LIMIT   = 4000;

    // One line of the directed table: either a budget write or a request,
    // optionally with its output bytes typed in (first byte in the top slot).
    typedef struct packed {
        logic              is_cfg;
        logic [15:0]       cfg_value;
        logic              typed;
        logic [2:0]        n_typed;
        logic [55:0]       typed_bytes;
        logic              closes;
        jse_pkg::in_item_t item;
    } dir_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               push      = 1'b0;
    logic               full;
    jse_pkg::in_item_t  in_item   = '0;
    logic               empty;
    logic               pop       = 1'b0;
    jse_pkg::out_item_t out_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data  = '0;

    // Escaper state as the testbench tracks it.
    logic        quote_open    = 1'b0;
    logic [15:0] bytes_emitted = '0;
    logic [15:0] budget        = jse_pkg::BUFFER_SIZE_RESET;

    jse_pkg::out_item_t escaped_bytes[$];
    jse_pkg::out_item_t expected_bytes[$];
    int          mismatches    = 0;
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    bit          hold_req      = 1'b0;
    int          stuck_cycles  = 0;

    json_string_escaper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Appends one output byte and advances the per-string count.
    function automatic void emit(input logic [7:0] b, input logic last);
        jse_pkg::out_item_t r;
        r.out_byte       = b;
        r.last_of_string = last;
        escaped_bytes.push_back(r);
        bytes_emitted = bytes_emitted + 16'd1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return jse_pkg::CHAR_ZERO + 8'(n);
        return CHAR_A_LOWER + 8'(n) - 8'd10;
    endfunction

    // Computes the output bytes that one accepted request produces.
    function automatic void escape_char(input jse_pkg::in_item_t it);
        logic [7:0] c;
        c = it.char_byte;
        escaped_bytes.delete();
        if (!quote_open)
        begin
            // A budget below the minimum yields only a bare terminator.
            if (budget < jse_pkg::MIN_BUFFER)
            begin
                if (it.end_of_string)
                    emit(jse_pkg::CHAR_NUL, 1'b1);
                bytes_emitted = '0;
                return;
            end
            bytes_emitted = '0;
            emit(jse_pkg::CHAR_QUOTE, 1'b0);
            quote_open = 1'b1;
        end
        if (it.end_of_string)
        begin
            // The closing quote ends the string when no room is left for the zero.
            emit(jse_pkg::CHAR_QUOTE, 1'b0);
            if (bytes_emitted < budget)
                emit(jse_pkg::CHAR_NUL, 1'b1);
            else
                escaped_bytes[escaped_bytes.size() - 1].last_of_string = 1'b1;
            quote_open    = 1'b0;
            bytes_emitted = '0;
            return;
        end
        // Characters beyond the budget are dropped without a trace.
        if ({1'b0, bytes_emitted} + jse_pkg::ENCODE_HEADROOM < {1'b0, budget})
        begin
            case (c)
                jse_pkg::CHAR_QUOTE:
                begin
                    emit(jse_pkg::CHAR_BACKSLASH, 1'b0);
                    emit(jse_pkg::CHAR_QUOTE, 1'b0);
                end
                jse_pkg::CHAR_BACKSLASH:
                begin
                    emit(jse_pkg::CHAR_BACKSLASH, 1'b0);
                    emit(jse_pkg::CHAR_BACKSLASH, 1'b0);
                end
                jse_pkg::CHAR_LF:
                begin
                    emit(jse_pkg::CHAR_BACKSLASH, 1'b0);
                    emit(jse_pkg::CHAR_N, 1'b0);
                end
                jse_pkg::CHAR_CR:
                begin
                    emit(jse_pkg::CHAR_BACKSLASH, 1'b0);
                    emit(jse_pkg::CHAR_R, 1'b0);
                end
                jse_pkg::CHAR_TAB:
                begin
                    emit(jse_pkg::CHAR_BACKSLASH, 1'b0);
                    emit(jse_pkg::CHAR_T, 1'b0);
                end
                default:
                begin
                    if (c < jse_pkg::CTRL_LIMIT)
                    begin
                        emit(jse_pkg::CHAR_BACKSLASH, 1'b0);
                        emit(jse_pkg::CHAR_U, 1'b0);
                        emit(jse_pkg::CHAR_ZERO, 1'b0);
                        emit(jse_pkg::CHAR_ZERO, 1'b0);
                        emit(hex_char(c[7:4]), 1'b0);
                        emit(hex_char(c[3:0]), 1'b0);
                    end
                    else
                        emit(c, 1'b0);
                end
            endcase
        end
    endfunction

    function automatic dir_row_t char_row(input logic [7:0] c, input logic eos);
        dir_row_t r;
        r = '0;
        r.item.char_byte     = c;
        r.item.end_of_string = eos;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [15:0] v);
        dir_row_t r;
        r = '0;
        r.is_cfg    = 1'b1;
        r.cfg_value = v;
        return r;
    endfunction

    function automatic dir_row_t typed_row(input logic [7:0] c, input logic eos,
                                           input logic [2:0] n, input logic [55:0] bytes,
                                           input logic closes);
        dir_row_t r;
        r = char_row(c, eos);
        r.typed       = 1'b1;
        r.n_typed     = n;
        r.typed_bytes = bytes;
        r.closes      = closes;
        return r;
    endfunction

    // Random characters lean toward escapes and control codes.
    function automatic jse_pkg::in_item_t random_item();
        jse_pkg::in_item_t it;
        it.char_byte     = 8'($urandom_range(255));
        it.end_of_string = ($urandom_range(7) == 0);
        case ($urandom_range(9))
            0, 1:
            begin
                case ($urandom_range(4))
                    0:       it.char_byte = jse_pkg::CHAR_QUOTE;
                    1:       it.char_byte = jse_pkg::CHAR_BACKSLASH;
                    2:       it.char_byte = jse_pkg::CHAR_LF;
                    3:       it.char_byte = jse_pkg::CHAR_CR;
                    default: it.char_byte = jse_pkg::CHAR_TAB;
                endcase
            end
            2:       it.char_byte = 8'($urandom_range(31));
            3:       ;
            default: it.char_byte = 8'($urandom_range(8'h7e, 8'h20));
        endcase
        return it;
    endfunction

    function automatic logic [15:0] pick_budget();
        case ($urandom_range(7))
            0:       return 16'($urandom_range(2));
            1:       return 16'($urandom_range(12, 3));
            2:       return 16'($urandom_range(60, 13));
            3:       return 16'hffff;
            4:       return 16'($urandom_range(16'hffff));
            default: return 16'($urandom_range(300, 61));
        endcase
    endfunction

    // Offers one request, waits for it to be taken, then predicts its output.
    task automatic send_item(input jse_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        escape_char(it);
    endtask

    // Stops offering, waits for every expected byte and lets dropped work drain.
    task automatic settle_idle();
        push <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_budget(input logic [15:0] v);
        settle_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        budget = v;
        cfg_valid <= 1'b0;
    endtask

    // Result side: checks each popped byte and drives pop with random stalls.
    initial
    begin : result_sink
        int                 stall_left;
        jse_pkg::out_item_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got byte %h last %b",
                             $time, out_item.out_byte, out_item.last_of_string);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_item.out_byte !== want.out_byte ||
                        out_item.last_of_string !== want.last_of_string)
                    begin
                        mismatches++;
                        $display("%0t: mismatch, expected byte %h last %b, got byte %h last %b",
                                 $time, want.out_byte, want.last_of_string,
                                 out_item.out_byte, out_item.last_of_string);
                    end
                end
            end
            // A long hold lets the block fill up and push back on the sender.
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
            $display("json_string_escaper_core verification failed");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin : stimulus
        dir_row_t dir_rows[$];
        dir_row_t row;
        int       n;
        int       k;
        int       ph;
        int       blk;
        int       j;
        int       phase_send[4];
        int       phase_stall[4];

        // Default budget: the empty string, then every character class.
        dir_rows.push_back(typed_row(8'hff, 1'b1, 3'd3,
                                     56'({jse_pkg::CHAR_QUOTE, jse_pkg::CHAR_QUOTE,
                                          jse_pkg::CHAR_NUL}), 1'b1));
        dir_rows.push_back(typed_row(8'h41, 1'b0, 3'd2,
                                     56'({jse_pkg::CHAR_QUOTE, 8'h41}), 1'b0));
        dir_rows.push_back(typed_row(jse_pkg::CHAR_QUOTE, 1'b0, 3'd2,
                                     56'({jse_pkg::CHAR_BACKSLASH, jse_pkg::CHAR_QUOTE}),
                                     1'b0));
        dir_rows.push_back(typed_row(jse_pkg::CHAR_BACKSLASH, 1'b0, 3'd2,
                                     56'({jse_pkg::CHAR_BACKSLASH, jse_pkg::CHAR_BACKSLASH}),
                                     1'b0));
        dir_rows.push_back(typed_row(jse_pkg::CHAR_LF, 1'b0, 3'd2,
                                     56'({jse_pkg::CHAR_BACKSLASH, jse_pkg::CHAR_N}), 1'b0));
        dir_rows.push_back(typed_row(jse_pkg::CHAR_CR, 1'b0, 3'd2,
                                     56'({jse_pkg::CHAR_BACKSLASH, jse_pkg::CHAR_R}), 1'b0));
        dir_rows.push_back(typed_row(jse_pkg::CHAR_TAB, 1'b0, 3'd2,
                                     56'({jse_pkg::CHAR_BACKSLASH, jse_pkg::CHAR_T}), 1'b0));
        dir_rows.push_back(typed_row(8'h00, 1'b0, 3'd6,
                                     56'({jse_pkg::CHAR_BACKSLASH, jse_pkg::CHAR_U,
                                          jse_pkg::CHAR_ZERO, jse_pkg::CHAR_ZERO,
                                          jse_pkg::CHAR_ZERO, jse_pkg::CHAR_ZERO}), 1'b0));
        dir_rows.push_back(typed_row(8'h1f, 1'b0, 3'd6,
                                     56'({jse_pkg::CHAR_BACKSLASH, jse_pkg::CHAR_U,
                                          jse_pkg::CHAR_ZERO, jse_pkg::CHAR_ZERO,
                                          8'h31, 8'h66}), 1'b0));
        dir_rows.push_back(typed_row(8'h20, 1'b0, 3'd1, 56'(8'h20), 1'b0));
        dir_rows.push_back(typed_row(8'hff, 1'b0, 3'd1, 56'(8'hff), 1'b0));
        dir_rows.push_back(char_row(8'h7f, 1'b0));
        dir_rows.push_back(typed_row(8'h00, 1'b1, 3'd2,
                                     56'({jse_pkg::CHAR_QUOTE, jse_pkg::CHAR_NUL}), 1'b1));
        // Zero budget: characters vanish, the end marker gives a lone terminator.
        dir_rows.push_back(cfg_row(16'd0));
        dir_rows.push_back(typed_row(CHAR_A_LOWER, 1'b0, 3'd0, '0, 1'b0));
        dir_rows.push_back(typed_row(CHAR_A_LOWER, 1'b1, 3'd1, 56'(jse_pkg::CHAR_NUL), 1'b1));
        // Smallest usable budget: only the quotes and the terminator fit.
        dir_rows.push_back(cfg_row(jse_pkg::MIN_BUFFER));
        dir_rows.push_back(char_row(CHAR_A_LOWER, 1'b0));
        dir_rows.push_back(char_row(8'h00, 1'b1));
        // Budget runs out, is raised mid-string, then lowered below the count.
        dir_rows.push_back(cfg_row(16'd10));
        dir_rows.push_back(char_row(CHAR_A_LOWER, 1'b0));
        dir_rows.push_back(char_row(8'h62, 1'b0));
        dir_rows.push_back(char_row(jse_pkg::CHAR_LF, 1'b0));
        dir_rows.push_back(cfg_row(16'hffff));
        dir_rows.push_back(char_row(jse_pkg::CHAR_BACKSLASH, 1'b0));
        dir_rows.push_back(char_row(8'h01, 1'b0));
        dir_rows.push_back(cfg_row(16'd4));
        dir_rows.push_back(char_row(8'h63, 1'b0));
        dir_rows.push_back(char_row(8'h80, 1'b1));

        phase_send  = '{0, 78, 0, 12};
        phase_stall = '{0, 0, 78, 12};

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_cfg)
                write_budget(row.cfg_value);
            else
            begin
                send_item(row.item);
                if (row.typed)
                begin
                    n = int'(row.n_typed);
                    for (k = 0; k < n; k++)
                        expected_bytes.push_back({row.typed_bytes[8 * (n - 1 - k) +: 8],
                                                  row.closes && (k == n - 1)});
                end
                else
                    foreach (escaped_bytes[m])
                        expected_bytes.push_back(escaped_bytes[m]);
            end
        end

        // Random strings under each idling pattern, with a new budget per block.
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = phase_send[ph];
            pop_stall_pct = phase_stall[ph];
            for (blk = 0; blk < 4; blk++)
            begin
                write_budget(pick_budget());
                for (j = 0; j < 22; j++)
                begin
                    send_item(random_item());
                    foreach (escaped_bytes[m])
                        expected_bytes.push_back(escaped_bytes[m]);
                end
            end
        end

        // Receiver holds off while the sender keeps offering requests.
        write_budget(16'd1000);
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_req      = 1'b1;
        for (j = 0; j < 40; j++)
        begin
            send_item(random_item());
            foreach (escaped_bytes[m])
                expected_bytes.push_back(escaped_bytes[m]);
        end

        settle_idle();
        if (mismatches == 0)
            $display("json_string_escaper_core verification clean");
        else
            $display("json_string_escaper_core verification failed");
        $finish;
    end

endmodule
